// ===== hw/rtl/nmpp_pkg.sv =====
// Package for the NMEA position and heading parser.
// Holds the word types of both channels and the fixed sentence offsets.
// No dependencies.
`default_nettype none

package nmpp_pkg;

    // One input word: a sentence character and its end marker.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
    } nmpp_in_t;

    // One result word, emitted once per sentence.
    typedef struct packed {
        logic        [6:0]  lat_degrees;
        logic signed [27:0] lat_microminutes;
        logic        [9:0]  lon_degrees;
        logic signed [27:0] lon_microminutes;
        logic        [13:0] heading_value;
        logic               heading_found;
    } nmpp_out_t;

    // Parsed values held between the parse stage and the output stage.
    typedef struct packed {
        logic [6:0]  lat_deg;
        logic [6:0]  lat_min;
        logic [19:0] lat_frac;
        logic        south;
        logic [9:0]  lon_deg;
        logic [6:0]  lon_min;
        logic [19:0] lon_frac;
        logic        west;
        logic [13:0] heading;
        logic        found;
    } nmpp_snap_t;

    // Character positions of the fixed-format fields.
    localparam logic [6:0] POS_LAT_DEG_LO  = 7'd18;
    localparam logic [6:0] POS_LAT_DEG_HI  = 7'd19;
    localparam logic [6:0] POS_LAT_MIN_LO  = 7'd20;
    localparam logic [6:0] POS_LAT_MIN_HI  = 7'd21;
    localparam logic [6:0] POS_LAT_FRAC_LO = 7'd23;
    localparam logic [6:0] POS_LAT_FRAC_HI = 7'd28;
    localparam logic [6:0] POS_NS          = 7'd30;
    localparam logic [6:0] POS_LON_DEG_LO  = 7'd32;
    localparam logic [6:0] POS_LON_DEG_HI  = 7'd34;
    localparam logic [6:0] POS_LON_MIN_LO  = 7'd35;
    localparam logic [6:0] POS_LON_MIN_HI  = 7'd36;
    localparam logic [6:0] POS_LON_FRAC_LO = 7'd38;
    localparam logic [6:0] POS_LON_FRAC_HI = 7'd43;
    localparam logic [6:0] POS_EW          = 7'd45;
    localparam logic [6:0] POS_MAX         = 7'd127;

    // Heading follows this comma; offsets within that field.
    localparam logic [3:0] HEADING_COMMA = 4'd8;
    localparam logic [2:0] OFFSET_MAX    = 3'd7;
    localparam logic [2:0] HDG_OFF_1     = 3'd1;
    localparam logic [2:0] HDG_OFF_2     = 3'd2;
    localparam logic [2:0] HDG_OFF_3     = 3'd3;
    localparam logic [2:0] HDG_OFF_5     = 3'd5;

    // Characters of interest.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // Index of each number's stop flag.
    localparam int ST_LAT_DEG  = 0;
    localparam int ST_LAT_MIN  = 1;
    localparam int ST_LAT_FRAC = 2;
    localparam int ST_LON_DEG  = 3;
    localparam int ST_LON_MIN  = 4;
    localparam int ST_LON_FRAC = 5;
    localparam int ST_HEADING  = 6;

    localparam logic [26:0] MICRO = 27'd1000000;

endpackage

`default_nettype wire

// ===== hw/rtl/nmea_position_heading_parser_top.sv =====
// Top level of the NMEA position and heading parser.
// Depends on nmpp_pkg for the word types and sentence offsets.
//
// Usage: the s_ channel carries one sentence character per word, with last
// set on the final character. Position 0 is the character after the previous
// last-marked one. The m_ channel carries one result word per sentence,
// holding latitude and longitude degrees, signed micro-minutes (negative for
// south or west) and the heading found after the eighth comma.
// Throughput: one character per cycle while s_ready is high, set by the
// update of the parse state registers; nothing iterates.
// The snapshot stage captures the finished values at the edge that accepts
// the last character; the output stage, where the minutes are scaled by one
// million, loads from it once the output register is empty or being taken,
// and m_valid rises as the output stage loads.
// Reset (aresetn low at a clock edge) clears the parse state and empties both
// stages. When the receiver stalls, one finished sentence waits in the output
// register and a second in the snapshot stage; once both are full, s_ready
// stays low for every character until m_ready frees a slot.
`default_nettype none

module nmea_position_heading_parser_top
    import nmpp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire nmpp_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output nmpp_out_t      m_data
);

    // Parse state.
    logic [6:0]  pos_reg,       pos_next;
    logic [3:0]  comma_reg,     comma_next;
    logic [2:0]  offset_reg,    offset_next;
    logic [6:0]  lat_deg_reg,   lat_deg_next;
    logic [6:0]  lat_min_reg,   lat_min_next;
    logic [19:0] lat_frac_reg,  lat_frac_next;
    logic [9:0]  lon_deg_reg,   lon_deg_next;
    logic [6:0]  lon_min_reg,   lon_min_next;
    logic [19:0] lon_frac_reg,  lon_frac_next;
    logic [13:0] heading_reg,   heading_next;
    logic [6:0]  stop_reg,      stop_next;
    logic        south_reg,     south_next;
    logic        west_reg,      west_next;

    // Pipeline stages.
    nmpp_snap_t  snap_reg;
    logic        snap_valid_reg;
    nmpp_out_t   out_reg;
    logic        out_valid_reg;

    logic        in_fire;
    logic        out_load;
    logic        is_digit;
    logic [3:0]  digit;
    logic [7:0]  ch;
    logic [2:0]  off_inc;
    logic        found_next;
    logic [26:0] lat_mag;
    logic [26:0] lon_mag;
    logic [27:0] lat_mag_ext;
    logic [27:0] lon_mag_ext;

    // Handshake: the output stage frees the snapshot stage, which frees the input.
    assign out_load = snap_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !snap_valid_reg || out_load;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign ch       = s_data.char_byte;
    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    assign digit    = ch[3:0];
    assign off_inc  = (offset_reg < OFFSET_MAX) ? offset_reg + 3'd1 : OFFSET_MAX;

    // Next parse state for the current character.
    always_comb begin
        pos_next      = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : POS_MAX;
        comma_next    = comma_reg;
        offset_next   = offset_reg;
        lat_deg_next  = lat_deg_reg;
        lat_min_next  = lat_min_reg;
        lat_frac_next = lat_frac_reg;
        lon_deg_next  = lon_deg_reg;
        lon_min_next  = lon_min_reg;
        lon_frac_next = lon_frac_reg;
        heading_next  = heading_reg;
        stop_next     = stop_reg;
        south_next    = south_reg;
        west_next     = west_reg;

        // Fixed-position fields; a non-digit freezes the number.
        if (pos_reg >= POS_LAT_DEG_LO && pos_reg <= POS_LAT_DEG_HI) begin
            if (!stop_reg[ST_LAT_DEG]) begin
                if (is_digit) begin
                    lat_deg_next = 7'(lat_deg_reg * 7'd10) + 7'(digit);
                end else begin
                    stop_next[ST_LAT_DEG] = 1'b1;
                end
            end
        end else if (pos_reg >= POS_LAT_MIN_LO && pos_reg <= POS_LAT_MIN_HI) begin
            if (!stop_reg[ST_LAT_MIN]) begin
                if (is_digit) begin
                    lat_min_next = 7'(lat_min_reg * 7'd10) + 7'(digit);
                end else begin
                    stop_next[ST_LAT_MIN] = 1'b1;
                end
            end
        end else if (pos_reg >= POS_LAT_FRAC_LO && pos_reg <= POS_LAT_FRAC_HI) begin
            if (!stop_reg[ST_LAT_FRAC]) begin
                if (is_digit) begin
                    lat_frac_next = 20'(lat_frac_reg * 20'd10) + 20'(digit);
                end else begin
                    stop_next[ST_LAT_FRAC] = 1'b1;
                end
            end
        end else if (pos_reg == POS_NS && ch == CH_S) begin
            south_next = 1'b1;
        end else if (pos_reg >= POS_LON_DEG_LO && pos_reg <= POS_LON_DEG_HI) begin
            if (!stop_reg[ST_LON_DEG]) begin
                if (is_digit) begin
                    lon_deg_next = 10'(lon_deg_reg * 10'd10) + 10'(digit);
                end else begin
                    stop_next[ST_LON_DEG] = 1'b1;
                end
            end
        end else if (pos_reg >= POS_LON_MIN_LO && pos_reg <= POS_LON_MIN_HI) begin
            if (!stop_reg[ST_LON_MIN]) begin
                if (is_digit) begin
                    lon_min_next = 7'(lon_min_reg * 7'd10) + 7'(digit);
                end else begin
                    stop_next[ST_LON_MIN] = 1'b1;
                end
            end
        end else if (pos_reg >= POS_LON_FRAC_LO && pos_reg <= POS_LON_FRAC_HI) begin
            if (!stop_reg[ST_LON_FRAC]) begin
                if (is_digit) begin
                    lon_frac_next = 20'(lon_frac_reg * 20'd10) + 20'(digit);
                end else begin
                    stop_next[ST_LON_FRAC] = 1'b1;
                end
            end
        end else if (pos_reg == POS_EW && ch == CH_W) begin
            west_next = 1'b1;
        end

        // Comma counting, then the heading digits after the eighth comma.
        if (comma_reg >= HEADING_COMMA) begin
            offset_next = off_inc;
            if (off_inc == HDG_OFF_1 || off_inc == HDG_OFF_2 ||
                off_inc == HDG_OFF_3 || off_inc == HDG_OFF_5) begin
                if (!stop_reg[ST_HEADING]) begin
                    if (is_digit) begin
                        heading_next = 14'(heading_reg * 14'd10) + 14'(digit);
                    end else begin
                        stop_next[ST_HEADING] = 1'b1;
                    end
                end
            end
        end else if (ch == CH_COMMA) begin
            comma_next  = comma_reg + 4'd1;
            offset_next = 3'd0;
        end
    end

    assign found_next = (comma_next >= HEADING_COMMA);

    // Parse state registers; cleared at reset and after each final character.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && s_data.last)) begin
            pos_reg      <= 7'd0;
            comma_reg    <= 4'd0;
            offset_reg   <= 3'd0;
            lat_deg_reg  <= 7'd0;
            lat_min_reg  <= 7'd0;
            lat_frac_reg <= 20'd0;
            lon_deg_reg  <= 10'd0;
            lon_min_reg  <= 7'd0;
            lon_frac_reg <= 20'd0;
            heading_reg  <= 14'd0;
            stop_reg     <= 7'd0;
            south_reg    <= 1'b0;
            west_reg     <= 1'b0;
        end else if (in_fire) begin
            pos_reg      <= pos_next;
            comma_reg    <= comma_next;
            offset_reg   <= offset_next;
            lat_deg_reg  <= lat_deg_next;
            lat_min_reg  <= lat_min_next;
            lat_frac_reg <= lat_frac_next;
            lon_deg_reg  <= lon_deg_next;
            lon_min_reg  <= lon_min_next;
            lon_frac_reg <= lon_frac_next;
            heading_reg  <= heading_next;
            stop_reg     <= stop_next;
            south_reg    <= south_next;
            west_reg     <= west_next;
        end
    end

    // Snapshot stage: captures the finished values of a sentence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (in_fire && s_data.last) begin
            snap_valid_reg <= 1'b1;
        end else if (out_load) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_data.last) begin
            snap_reg.lat_deg  <= lat_deg_next;
            snap_reg.lat_min  <= lat_min_next;
            snap_reg.lat_frac <= lat_frac_next;
            snap_reg.south    <= south_next;
            snap_reg.lon_deg  <= lon_deg_next;
            snap_reg.lon_min  <= lon_min_next;
            snap_reg.lon_frac <= lon_frac_next;
            snap_reg.west     <= west_next;
            snap_reg.heading  <= found_next ? heading_next : 14'd0;
            snap_reg.found    <= found_next;
        end
    end

    // Micro-minutes: minutes scaled by one million plus the fraction.
    assign lat_mag     = 27'(snap_reg.lat_min) * MICRO + 27'(snap_reg.lat_frac);
    assign lon_mag     = 27'(snap_reg.lon_min) * MICRO + 27'(snap_reg.lon_frac);
    assign lat_mag_ext = {1'b0, lat_mag};
    assign lon_mag_ext = {1'b0, lon_mag};

    // Output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.lat_degrees      <= snap_reg.lat_deg;
            out_reg.lat_microminutes <= $signed(snap_reg.south ? -lat_mag_ext : lat_mag_ext);
            out_reg.lon_degrees      <= snap_reg.lon_deg;
            out_reg.lon_microminutes <= $signed(snap_reg.west ? -lon_mag_ext : lon_mag_ext);
            out_reg.heading_value    <= snap_reg.heading;
            out_reg.heading_found    <= snap_reg.found;
        end
    end

endmodule

`default_nettype wire
